### src/affinity_chunk_dispatcher_top_macros.svh
// Assertion macros used by the checker file of the chunk dispatcher.
`ifndef AFFINITY_CHUNK_DISPATCHER_TOP_MACROS_SVH
`define AFFINITY_CHUNK_DISPATCHER_TOP_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define ACD_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("chunk dispatcher check failed");

// Consequent checked in the cycle after the antecedent.
`define ACD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("chunk dispatcher check failed");

`endif

### src/acd_pkg.sv
// Shared constants and types of the affinity chunk dispatcher.
`default_nettype none

package acd_pkg;

   localparam int MAX_WORKERS = 16;
   localparam int INDEX_BITS  = 16;
   localparam int WORKER_W    = $clog2(MAX_WORKERS);
   localparam int COUNT_W     = WORKER_W + 1;
   localparam int DIVIDEND_W  = INDEX_BITS + 1;
   localparam int STEP_W      = $clog2(DIVIDEND_W + 1);
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_IDX_W-1:0] REG_TOTAL   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_WORKERS = 2'd1;

   localparam logic [INDEX_BITS-1:0] TOTAL_RESET   = 16'd1729;
   localparam logic [COUNT_W-1:0]    WORKERS_RESET = 5'd4;

   localparam logic CMD_START = 1'b0;
   localparam logic CMD_NEXT  = 1'b1;

   typedef logic [INDEX_BITS-1:0] idx_type;
   typedef logic [WORKER_W-1:0]   wid_type;
   typedef logic [COUNT_W-1:0]    cnt_type;

   typedef struct packed {
      idx_type stop;
      idx_type fin;
   } entry_type;

   typedef struct packed {
      wid_type worker;
      logic    has_work;
      idx_type chunk_lo;
      idx_type chunk_hi;
      logic    stolen;
      wid_type victim;
      logic    last;
   } rsp_type;

   typedef struct packed {
      logic                  start;
      logic [DIVIDEND_W-1:0] dividend;
      cnt_type               divisor;
   } div_req_type;

   typedef struct packed {
      logic    done;
      idx_type quotient;
   } div_rsp_type;

endpackage

`default_nettype wire

### src/acd_if.sv
// Channel interfaces of the chunk dispatcher: requests, results and register writes.
`default_nettype none

interface acd_req_if;
   logic              valid;
   logic              ready;
   logic              cmd;
   acd_pkg::wid_type  worker_id;

   modport source (output valid, output cmd, output worker_id, input ready);
   modport sink (input valid, input cmd, input worker_id, output ready);
endinterface

interface acd_rsp_if;
   logic              valid;
   logic              ready;
   acd_pkg::wid_type  worker;
   logic              has_work;
   acd_pkg::idx_type  chunk_lo;
   acd_pkg::idx_type  chunk_hi;
   logic              stolen;
   acd_pkg::wid_type  victim;
   logic              last;

   modport source (output valid, output worker, output has_work, output chunk_lo,
                   output chunk_hi, output stolen, output victim, output last,
                   input ready);
   modport sink (input valid, input worker, input has_work, input chunk_lo,
                 input chunk_hi, input stolen, input victim, input last,
                 output ready);
endinterface

interface acd_csr_if;
   logic                             valid;
   logic                             ready;
   logic [acd_pkg::CSR_IDX_W-1:0]    index;
   logic [acd_pkg::CSR_DATA_W-1:0]   data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### src/acd_div.sv
// Iterative restoring divider, one quotient bit per cycle.
`default_nettype none

module acd_div (
   input  wire                  clock,
   input  wire                  reset,
   input  acd_pkg::div_req_type req_in,
   output acd_pkg::div_rsp_type rsp_out
);

   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [acd_pkg::STEP_W-1:0]        cnt_ff, cnt_in;
   logic [acd_pkg::DIVIDEND_W-1:0]    quo_ff, quo_in;
   acd_pkg::cnt_type                  rem_ff, rem_in;
   acd_pkg::cnt_type                  dsr_ff, dsr_in;
   logic [acd_pkg::COUNT_W:0]         trial;
   logic [acd_pkg::COUNT_W:0]         diff;
   logic                              fits;

   assign trial = {rem_ff, quo_ff[acd_pkg::DIVIDEND_W-1]};
   assign fits  = trial >= {1'b0, dsr_ff};
   assign diff  = trial - {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (req_in.start) begin
         busy_in = 1'b1;
         cnt_in  = acd_pkg::STEP_W'(acd_pkg::DIVIDEND_W);
         quo_in  = req_in.dividend;
         rem_in  = '0;
         dsr_in  = req_in.divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[acd_pkg::DIVIDEND_W-2:0], fits};
         rem_in = fits ? diff[acd_pkg::COUNT_W-1:0] : trial[acd_pkg::COUNT_W-1:0];
         cnt_in = cnt_ff - acd_pkg::STEP_W'(1);
         if (cnt_ff == acd_pkg::STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign rsp_out.done     = done_ff;
   assign rsp_out.quotient = quo_ff[acd_pkg::INDEX_BITS-1:0];

endmodule

`default_nettype wire

### src/acd_engine.sv
// Sequencer and per-worker state memory of the chunk dispatcher.
`default_nettype none

module acd_engine (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   item_valid,
   output logic                  item_ready,
   input  wire                   item_cmd,
   input  acd_pkg::wid_type      item_worker,
   input  acd_pkg::idx_type      total,
   input  acd_pkg::cnt_type      workers,
   output logic                  res_valid,
   input  wire                   res_ready,
   output acd_pkg::rsp_type      res_data,
   output acd_pkg::div_req_type  div_req,
   input  acd_pkg::div_rsp_type  div_rsp
);

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_DIV_IPT   = 4'd1;
   localparam logic [3:0] S_DIV_FIRST = 4'd2;
   localparam logic [3:0] S_FILL      = 4'd3;
   localparam logic [3:0] S_READ      = 4'd4;
   localparam logic [3:0] S_DIV_CHUNK = 4'd5;
   localparam logic [3:0] S_SCAN      = 4'd6;
   localparam logic [3:0] S_STEAL     = 4'd7;
   localparam logic [3:0] S_THIEF     = 4'd8;
   localparam logic [3:0] S_EMIT      = 4'd9;

   localparam int IW = acd_pkg::INDEX_BITS;
   localparam int DW = acd_pkg::DIVIDEND_W;
   localparam int CW = acd_pkg::COUNT_W;

   logic [3:0]          state_ff, state_in;
   acd_pkg::idx_type    ipt_ff, ipt_in;
   acd_pkg::idx_type    first_ff, first_in;
   acd_pkg::idx_type    lo_ff, lo_in;
   acd_pkg::wid_type    idx_ff, idx_in;
   acd_pkg::wid_type    wid_ff, wid_in;
   acd_pkg::idx_type    cur_ff, cur_in;
   acd_pkg::idx_type    fin_ff, fin_in;
   acd_pkg::wid_type    scan_ff, scan_in;
   acd_pkg::idx_type    best_ff, best_in;
   acd_pkg::wid_type    vic_ff, vic_in;
   logic                found_ff, found_in;
   acd_pkg::idx_type    blo_ff, blo_in;
   acd_pkg::idx_type    bhi_ff, bhi_in;
   acd_pkg::rsp_type    res_ff, res_in;

   acd_pkg::entry_type                      mem [acd_pkg::MAX_WORKERS];
   logic [acd_pkg::MAX_WORKERS-1:0]         valid_ff;
   acd_pkg::entry_type                      rd_data_ff;
   logic                                    rd_valid_ff;
   acd_pkg::entry_type                      rd_entry;
   logic                                    rd_en;
   acd_pkg::wid_type                        rd_addr;
   logic                                    wr_en;
   acd_pkg::wid_type                        wr_addr;
   acd_pkg::entry_type                      wr_data;

   logic [IW:0]         fill_sum;
   acd_pkg::idx_type    fill_fin;
   logic [IW:0]         fill_first;
   acd_pkg::idx_type    fill_stop;
   logic                fill_last;
   acd_pkg::rsp_type    fill_res;

   acd_pkg::idx_type    chunk_step;
   logic [IW:0]         chunk_sum;
   acd_pkg::idx_type    chunk_stop;

   acd_pkg::idx_type    scan_rem;
   logic                scan_take;
   logic                scan_last;

   assign rd_entry = rd_valid_ff ? rd_data_ff : '0;

   assign fill_sum   = {1'b0, lo_ff} + {1'b0, ipt_ff};
   assign fill_fin   = (fill_sum > {1'b0, total}) ? total : fill_sum[IW-1:0];
   assign fill_first = {1'b0, lo_ff} + {1'b0, first_ff};
   assign fill_stop  = (fill_first > {1'b0, fill_fin}) ? fill_fin : fill_first[IW-1:0];
   assign fill_last  = (CW'(idx_ff) + CW'(1)) == workers;
   assign fill_res   = '{worker: idx_ff, has_work: (lo_ff < fill_stop), chunk_lo: lo_ff,
                         chunk_hi: fill_stop, stolen: 1'b0, victim: '0, last: fill_last};

   assign chunk_step = (div_rsp.quotient == '0) ? IW'(1) : div_rsp.quotient;
   assign chunk_sum  = {1'b0, cur_ff} + {1'b0, chunk_step};
   assign chunk_stop = (chunk_sum > {1'b0, fin_ff}) ? fin_ff : chunk_sum[IW-1:0];

   assign scan_rem  = rd_entry.fin - rd_entry.stop;
   assign scan_take = (rd_entry.stop < rd_entry.fin) && (scan_rem > best_ff);
   assign scan_last = (CW'(scan_ff) + CW'(1)) == workers;

   always_comb begin
      state_in = state_ff;
      ipt_in   = ipt_ff;
      first_in = first_ff;
      lo_in    = lo_ff;
      idx_in   = idx_ff;
      wid_in   = wid_ff;
      cur_in   = cur_ff;
      fin_in   = fin_ff;
      scan_in  = scan_ff;
      best_in  = best_ff;
      vic_in   = vic_ff;
      found_in = found_ff;
      blo_in   = blo_ff;
      bhi_in   = bhi_ff;
      res_in   = res_ff;

      item_ready = (state_ff == S_IDLE);
      res_valid  = 1'b0;
      res_data   = res_ff;
      div_req          = '0;
      div_req.divisor  = workers;
      rd_en   = 1'b0;
      rd_addr = scan_ff;
      wr_en   = 1'b0;
      wr_addr = wid_ff;
      wr_data = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (item_valid) begin
               wid_in = item_worker;
               if (item_cmd == acd_pkg::CMD_START) begin
                  div_req.start    = 1'b1;
                  div_req.dividend = {1'b0, total} + DW'(workers) - DW'(1);
                  state_in         = S_DIV_IPT;
               end else if (CW'(item_worker) >= workers) begin
                  res_in        = '0;
                  res_in.worker = item_worker;
                  res_in.last   = 1'b1;
                  state_in      = S_EMIT;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = item_worker;
                  state_in = S_READ;
               end
            end
         end
         S_DIV_IPT: begin
            if (div_rsp.done) begin
               ipt_in           = div_rsp.quotient;
               div_req.start    = 1'b1;
               div_req.dividend = {1'b0, div_rsp.quotient} + DW'(workers) - DW'(1);
               state_in         = S_DIV_FIRST;
            end
         end
         S_DIV_FIRST: begin
            if (div_rsp.done) begin
               first_in = div_rsp.quotient;
               lo_in    = '0;
               idx_in   = '0;
               state_in = S_FILL;
            end
         end
         S_FILL: begin
            res_valid = 1'b1;
            res_data  = fill_res;
            if (res_ready) begin
               wr_en   = 1'b1;
               wr_addr = idx_ff;
               wr_data = '{stop: fill_stop, fin: fill_fin};
               lo_in   = fill_fin;
               idx_in  = idx_ff + acd_pkg::WORKER_W'(1);
               if (fill_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         S_READ: begin
            cur_in = rd_entry.stop;
            fin_in = rd_entry.fin;
            if (rd_entry.stop < rd_entry.fin) begin
               div_req.start    = 1'b1;
               div_req.dividend = {1'b0, rd_entry.fin - rd_entry.stop};
               state_in         = S_DIV_CHUNK;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = '0;
               scan_in  = '0;
               found_in = 1'b0;
               best_in  = '0;
               state_in = S_SCAN;
            end
         end
         S_DIV_CHUNK: begin
            if (div_rsp.done) begin
               wr_en    = 1'b1;
               wr_addr  = wid_ff;
               wr_data  = '{stop: chunk_stop, fin: fin_ff};
               res_in   = '{worker: wid_ff, has_work: 1'b1, chunk_lo: cur_ff,
                            chunk_hi: chunk_stop, stolen: 1'b0, victim: '0, last: 1'b1};
               state_in = S_EMIT;
            end
         end
         S_SCAN: begin
            if (scan_take) begin
               best_in  = scan_rem;
               vic_in   = scan_ff;
               found_in = 1'b1;
               blo_in   = rd_entry.stop;
               bhi_in   = rd_entry.fin;
            end
            if (scan_last) begin
               state_in = S_STEAL;
            end else begin
               rd_en   = 1'b1;
               rd_addr = scan_ff + acd_pkg::WORKER_W'(1);
               scan_in = scan_ff + acd_pkg::WORKER_W'(1);
            end
         end
         S_STEAL: begin
            if (!found_ff) begin
               res_in        = '0;
               res_in.worker = wid_ff;
               res_in.last   = 1'b1;
               state_in      = S_EMIT;
            end else begin
               wr_en    = 1'b1;
               wr_addr  = vic_ff;
               wr_data  = '{stop: blo_ff, fin: blo_ff};
               res_in   = '{worker: wid_ff, has_work: 1'b1, chunk_lo: blo_ff,
                            chunk_hi: bhi_ff, stolen: 1'b1, victim: vic_ff, last: 1'b1};
               state_in = S_THIEF;
            end
         end
         S_THIEF: begin
            wr_en    = 1'b1;
            wr_addr  = wid_ff;
            wr_data  = '{stop: bhi_ff, fin: bhi_ff};
            state_in = S_EMIT;
         end
         S_EMIT: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      ipt_ff   <= ipt_in;
      first_ff <= first_in;
      lo_ff    <= lo_in;
      idx_ff   <= idx_in;
      wid_ff   <= wid_in;
      cur_ff   <= cur_in;
      fin_ff   <= fin_in;
      scan_ff  <= scan_in;
      best_ff  <= best_in;
      vic_ff   <= vic_in;
      found_ff <= found_in;
      blo_ff   <= blo_in;
      bhi_ff   <= bhi_in;
      res_ff   <= res_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

endmodule

`default_nettype wire

### src/affinity_chunk_dispatcher_top.sv
// A start runs two divisions, then gives one result per cycle while the output is not stalled.
// A request whose own block has work runs one division in the 17-step divider.
// A request that must steal scans every worker, one memory read per worker scanned.
// Only one transaction is in flight: a new request is taken only after the last result is handed on.
// The output register lets the engine hand over a result in the same cycle as the held one is taken.
// Synchronous reset clears the per-worker state and restores both configuration registers.
`default_nettype none

module affinity_chunk_dispatcher_top (
   input  wire          clock,
   input  wire          reset,
   acd_req_if.sink      req_ch,
   acd_rsp_if.source    rsp_ch,
   acd_csr_if.sink      csr_ch
);

   acd_pkg::idx_type      total_ff;
   acd_pkg::cnt_type      workers_ff;
   acd_pkg::cnt_type      workers_eff;
   logic                  rsp_valid_ff, rsp_valid_in;
   acd_pkg::rsp_type      rsp_data_ff, rsp_data_in;
   logic                  eng_valid;
   logic                  eng_ready;
   acd_pkg::rsp_type      eng_data;
   acd_pkg::div_req_type  div_req;
   acd_pkg::div_rsp_type  div_rsp;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff   <= acd_pkg::TOTAL_RESET;
         workers_ff <= acd_pkg::WORKERS_RESET;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            acd_pkg::REG_TOTAL:   total_ff   <= csr_ch.data[acd_pkg::INDEX_BITS-1:0];
            acd_pkg::REG_WORKERS: workers_ff <= csr_ch.data[acd_pkg::COUNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      if (workers_ff == '0) begin
         workers_eff = acd_pkg::COUNT_W'(1);
      end else if (workers_ff > acd_pkg::COUNT_W'(acd_pkg::MAX_WORKERS)) begin
         workers_eff = acd_pkg::COUNT_W'(acd_pkg::MAX_WORKERS);
      end else begin
         workers_eff = workers_ff;
      end
   end

   assign eng_ready = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (eng_valid && eng_ready) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = eng_data;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.worker   = rsp_data_ff.worker;
   assign rsp_ch.has_work = rsp_data_ff.has_work;
   assign rsp_ch.chunk_lo = rsp_data_ff.chunk_lo;
   assign rsp_ch.chunk_hi = rsp_data_ff.chunk_hi;
   assign rsp_ch.stolen   = rsp_data_ff.stolen;
   assign rsp_ch.victim   = rsp_data_ff.victim;
   assign rsp_ch.last     = rsp_data_ff.last;

   acd_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .item_valid  (req_ch.valid),
      .item_ready  (req_ch.ready),
      .item_cmd    (req_ch.cmd),
      .item_worker (req_ch.worker_id),
      .total       (total_ff),
      .workers     (workers_eff),
      .res_valid   (eng_valid),
      .res_ready   (eng_ready),
      .res_data    (eng_data),
      .div_req     (div_req),
      .div_rsp     (div_rsp)
   );

   acd_div u_div (
      .clock   (clock),
      .reset   (reset),
      .req_in  (div_req),
      .rsp_out (div_rsp)
   );

endmodule

`default_nettype wire

### src/acd_checker.sv
// Port-level checks of the chunk dispatcher and their binding to the top level.
`default_nettype none
`include "affinity_chunk_dispatcher_top_macros.svh"

module acd_checker (
   input wire                   clock,
   input wire                   reset,
   input wire                   req_valid,
   input wire                   req_ready,
   input wire                   rsp_valid,
   input wire                   rsp_ready,
   input wire                   rsp_has_work,
   input wire                   rsp_stolen,
   input acd_pkg::wid_type      rsp_worker,
   input acd_pkg::idx_type      rsp_chunk_lo,
   input acd_pkg::idx_type      rsp_chunk_hi
);

   // The engine handles one transaction at a time.
   `ACD_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)

   // A stalled result keeps its worker and chunk bounds.
   `ACD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_worker) && $stable(rsp_chunk_lo) && $stable(rsp_chunk_hi))

   // A chunk that carries work is never empty.
   `ACD_ASSERT_NOW(a_work_nonempty, clock, reset, rsp_valid && rsp_has_work, rsp_chunk_lo < rsp_chunk_hi)

   // A stolen chunk always carries work.
   `ACD_ASSERT_NOW(a_stolen_has_work, clock, reset, rsp_valid && rsp_stolen, rsp_has_work)

endmodule

bind affinity_chunk_dispatcher_top acd_checker u_acd_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_ch.valid),
   .req_ready    (req_ch.ready),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .rsp_has_work (rsp_ch.has_work),
   .rsp_stolen   (rsp_ch.stolen),
   .rsp_worker   (rsp_ch.worker),
   .rsp_chunk_lo (rsp_ch.chunk_lo),
   .rsp_chunk_hi (rsp_ch.chunk_hi)
);

`default_nettype wire
